FILE: rtl/cfd_pkg.sv
// Shared constants and controller/datapath types for the circular FIR dot product.
`default_nettype none
package cfd_pkg;

  localparam int MAX_TAPS_DEF  = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;
  localparam int OUT_BITS      = 38;
  localparam int IDX_BITS      = 6;
  localparam int TAP_CNT_BITS  = 7;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [TAP_CNT_BITS-1:0] TAP_CNT_RST = 7'd64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PUSH = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic push;
    logic issue;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic issue_last;
    logic pipe_busy;
    logic out_full;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/cfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/cfd_ctrl.sv
// Sequencing state machine: clear pass, item intake, tap loop and result hand-off.
`default_nettype none
module cfd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_cmd_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  input  wire cfd_pkg::dp_sts_t  sts_i,
  output cfd_pkg::ctl_cmd_t      cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == cfd_pkg::CMD_PUSH) begin
            cmd_o.push = 1'b1;
            state_d    = ST_RUN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy && (!sts_i.out_full || out_ready_i)) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfd_datapath.sv
// Ring pointer, coefficient and delay RAMs, shared multiply-accumulate and output register.
`default_nettype none
module cfd_datapath #(
  parameter int MAX_TAPS = cfd_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cfd_pkg::TAP_CNT_BITS-1:0]    cfg_wdata_i,
  input  wire logic [cfd_pkg::IDX_BITS-1:0]        slot_i,
  input  wire logic [cfd_pkg::SAMPLE_BITS-1:0]     value_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [cfd_pkg::OUT_BITS-1:0]        out_data_o,
  input  wire cfd_pkg::ctl_cmd_t                   cmd_i,
  output cfd_pkg::dp_sts_t                         sts_o
);

  localparam int PTR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW    = PTR_W + 1;
  localparam int EW    = ((cfd_pkg::TAP_CNT_BITS > TW) ? cfd_pkg::TAP_CNT_BITS : TW) + 1;
  localparam int CW    = ((cfd_pkg::IDX_BITS > TW) ? cfd_pkg::IDX_BITS : TW) + 1;
  localparam int SB    = cfd_pkg::SAMPLE_BITS;
  localparam int PB    = cfd_pkg::PROD_BITS;
  localparam int OB    = cfd_pkg::OUT_BITS;

  logic [cfd_pkg::TAP_CNT_BITS-1:0] tap_count_q;
  logic [PTR_W-1:0] clr_addr_q;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [TW-1:0]    taps_q, taps_cur;
  logic [PTR_W-1:0] k_q, idx_q;
  logic [TW-1:0]    idx_inc;
  logic [PTR_W-1:0] wr_pos;
  logic [TW-1:0]    pos_inc;
  logic             rd_v_q, prod_v_q;
  logic signed [PB-1:0] prod_q;
  logic [OB-1:0]    acc_q;
  logic [OB-1:0]    out_q;
  logic             out_v_q;

  logic             coef_we, dly_we;
  logic [PTR_W-1:0] coef_waddr, dly_waddr;
  logic [SB-1:0]    coef_wdata, dly_wdata;
  logic [SB-1:0]    coef_rdata, dly_rdata;
  logic             slot_ok;

  // Active tap count: zero means one, clipped to the ring size.
  always_comb begin
    if (tap_count_q == '0) begin
      taps_cur = TW'(1);
    end else if (EW'(tap_count_q) > EW'(MAX_TAPS)) begin
      taps_cur = TW'(MAX_TAPS);
    end else begin
      taps_cur = TW'(tap_count_q);
    end
  end

  assign wr_pos  = (TW'(ptr_q) >= taps_cur) ? '0 : ptr_q;
  assign pos_inc = TW'(wr_pos) + TW'(1);
  assign ptr_d   = (pos_inc >= taps_cur) ? '0 : pos_inc[PTR_W-1:0];
  assign idx_inc = TW'(idx_q) + TW'(1);

  assign slot_ok    = CW'(slot_i) < CW'(MAX_TAPS);
  assign coef_we    = cmd_i.clear | (cmd_i.load & slot_ok);
  assign coef_waddr = cmd_i.clear ? clr_addr_q : PTR_W'(slot_i);
  assign coef_wdata = cmd_i.clear ? '0 : value_i;
  assign dly_we     = cmd_i.clear | cmd_i.push;
  assign dly_waddr  = cmd_i.clear ? clr_addr_q : wr_pos;
  assign dly_wdata  = cmd_i.clear ? '0 : value_i;

  cfd_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .raddr_i (k_q),
    .rdata_o (coef_rdata)
  );

  cfd_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_TAPS)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .raddr_i (idx_q),
    .rdata_o (dly_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= cfd_pkg::TAP_CNT_RST;
      clr_addr_q  <= '0;
      ptr_q       <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + PTR_W'(1);
      end
      if (cmd_i.push) begin
        ptr_q <= ptr_d;
      end
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
      if (cmd_i.out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      taps_q <= taps_cur;
      k_q    <= '0;
      idx_q  <= ptr_d;
      acc_q  <= '0;
    end else begin
      if (cmd_i.issue) begin
        k_q   <= k_q + PTR_W'(1);
        idx_q <= (idx_inc >= taps_q) ? '0 : idx_inc[PTR_W-1:0];
      end
      if (prod_v_q) begin
        acc_q <= acc_q + {{(OB - PB){prod_q[PB-1]}}, prod_q};
      end
    end
    prod_q <= $signed(coef_rdata) * $signed(dly_rdata);
    if (cmd_i.out_load) begin
      out_q <= acc_q;
    end
  end

  assign sts_o.clear_last = (clr_addr_q == PTR_W'(MAX_TAPS - 1));
  assign sts_o.issue_last = (TW'(k_q) == (taps_q - TW'(1)));
  assign sts_o.pipe_busy  = rd_v_q | prod_v_q;
  assign sts_o.out_full   = out_v_q;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_v_q || out_ready_i))
    else $error("result overwrote an unread beat");
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push || cmd_i.load) |-> !(cmd_i.clear || cmd_i.issue))
    else $error("item intake overlapped clear or tap loop");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (TW'(idx_q) < taps_q && TW'(k_q) < taps_q))
    else $error("tap read address out of ring");
  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(!(rd_v_q || prod_v_q)))
    else $error("result loaded before accumulation finished");
`endif

endmodule
`default_nettype wire

FILE: rtl/circular_fir_dot_product.sv
// Top level of the circular-buffer FIR dot product: controller plus datapath.
//
//  channel  | direction | beat carries
//  s_axis   | in        | tuser: command; tdata: coeff_index, value
//  m_axis   | out       | tdata: filter_out
//  cfg      | in        | tap_count write
//
// After reset both RAMs are zeroed, one entry a cycle; s_axis_tready stays low meanwhile.
// A load beat leaves the controller idle. A push beat holds s_axis_tready low until its
// result is loaded: one multiply-accumulate per tap through the shared multiplier, read
// from the coefficient and delay RAM ports, then the RAM read, product and accumulate
// registers drain. The result waits in an output register; a stalled m_axis holds the
// next push at its hand-off, refusing all beats meanwhile; loads before that push are taken.
`default_nettype none
module circular_fir_dot_product #(
  parameter int MAX_TAPS = cfd_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [cfd_pkg::TAP_CNT_BITS-1:0]      cfg_wdata_i,   // tap_count
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [cfd_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,  // coeff_index[5:0], value[21:6]
  input  wire logic                                  s_axis_tuser,  // command
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [cfd_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata   // filter_out[37:0]
);

  cfd_pkg::ctl_cmd_t                cmd;
  cfd_pkg::dp_sts_t                 sts;
  logic [cfd_pkg::OUT_BITS-1:0]     filter_out;

  cfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cfd_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .slot_i      (s_axis_tdata[cfd_pkg::IDX_BITS-1:0]),
    .value_i     (s_axis_tdata[cfd_pkg::IDX_BITS +: cfd_pkg::SAMPLE_BITS]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (filter_out),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign m_axis_tdata = {{(cfd_pkg::OUT_DATA_BITS - cfd_pkg::OUT_BITS){1'b0}}, filter_out};

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking stream testbench for circular_fir_dot_product with an in-bench filter model.
module testbench;

  localparam int SAMPLE_BITS    = cfd_pkg::SAMPLE_BITS;
  localparam int IDX_BITS       = cfd_pkg::IDX_BITS;
  localparam int TAP_CNT_BITS   = cfd_pkg::TAP_CNT_BITS;
  localparam int IN_DATA_BITS   = cfd_pkg::IN_DATA_BITS;
  localparam int OUT_BITS       = cfd_pkg::OUT_BITS;
  localparam int OUT_DATA_BITS  = cfd_pkg::OUT_DATA_BITS;
  localparam int MAX_TAPS_DEF   = cfd_pkg::MAX_TAPS_DEF;

  localparam int ITEMS          = 1800;
  localparam int DRAIN_CYCLES   = MAX_TAPS_DEF + 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic      cmd;
    int        idx;
    int        val;
    int        taps;
    bit        known;
    longint    sum;
  } stim_row_t;

  // directed table; a known sum is taken as typed, others come from the filter model
  stim_row_t dir_rows [23] = '{
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,  32767,   0, 1'b1, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0, -32768,   0, 1'b1, 0},
    '{ROW_BEAT, cfd_pkg::CMD_LOAD,  0, -32768,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_LOAD, 63,  32767,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_LOAD,  1,      1,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,      5,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH, 63,     -1,   0, 1'b0, 0},
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0,   1, 1'b0, 0},
    // pointer left beyond the new tap count: write restarts at slot zero
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0, -32768,   0, 1'b1, 1073741824},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,  32767,   0, 1'b1, -1073709056},
    // zero taps behaves as one
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,      1,   0, 1'b1, -32768},
    // above the maximum saturates
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0, 127, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_LOAD,  0,  32767,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH, 42, -32768,   0, 1'b0, 0},
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0,   2, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_LOAD,  1, -32768,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,      3,   0, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,      4,   0, 1'b0, 0},
    // slot outside the active taps is kept, not used
    '{ROW_BEAT, cfd_pkg::CMD_LOAD,  2,    100,   0, 1'b0, 0},
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0,   3, 1'b0, 0},
    '{ROW_BEAT, cfd_pkg::CMD_PUSH,  0,     -7,   0, 1'b0, 0},
    '{ROW_CFG,  cfd_pkg::CMD_LOAD,  0,      0,  64, 1'b0, 0}
  };

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [TAP_CNT_BITS-1:0]   cfg_wdata_i   = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;  // coeff_index[5:0], value[21:6]
  logic                      s_axis_tuser  = 1'b0; // command
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;       // filter_out[37:0]

  // filter model state
  logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS_DEF];
  logic signed [SAMPLE_BITS-1:0] coeff_mem [MAX_TAPS_DEF];
  int unsigned                   wr_ptr;
  logic [TAP_CNT_BITS-1:0]       tap_reg;

  logic [OUT_BITS-1:0] pending_sums [$];

  int n_errors    = 0;
  int n_checked   = 0;
  int n_items     = 0;
  int n_loads     = 0;
  int n_pushes    = 0;
  int n_cfg       = 0;
  int burst_left  = 0;
  int hold_asked  = 0;
  int hold_served = 0;

  circular_fir_dot_product u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int active_taps(logic [TAP_CNT_BITS-1:0] t);
    if (t == 0) return 1;
    if (t > MAX_TAPS_DEF) return MAX_TAPS_DEF;
    return int'(t);
  endfunction

  // write the sample at the ring pointer, advance it, return the tap sum
  function automatic logic [OUT_BITS-1:0] push_and_filter(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned n;
    int unsigned p;
    int unsigned j;
    longint      acc;
    n = active_taps(tap_reg);
    p = wr_ptr;
    if (p >= n) p = 0;
    delay_mem[p] = s;
    p++;
    if (p >= n) p = 0;
    wr_ptr = p;
    acc = 0;
    j = p;
    for (int unsigned k = 0; k < n; k++) begin
      acc += longint'(delay_mem[j]) * longint'(coeff_mem[k]);
      j++;
      if (j >= n) j = 0;
    end
    return acc[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic cmd, logic [IDX_BITS-1:0] idx,
                           logic signed [SAMPLE_BITS-1:0] val, bit known,
                           logic [OUT_BITS-1:0] typed_sum);
    int gap;
    logic [OUT_BITS-1:0] sum;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (cmd == cfd_pkg::CMD_PUSH) begin
      sum = push_and_filter(val);
      pending_sums.push_back(known ? typed_sum : sum);
      n_pushes++;
    end else begin
      coeff_mem[idx] = val;
      n_loads++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_taps(logic [TAP_CNT_BITS-1:0] t);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    tap_reg = t;
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  initial begin : stimulus
    int n;
    int n_phase;
    logic [TAP_CNT_BITS-1:0] t;
    logic [IDX_BITS-1:0] idx;
    foreach (delay_mem[i]) begin
      delay_mem[i] = '0;
      coeff_mem[i] = '0;
    end
    wr_ptr  = 0;
    tap_reg = cfd_pkg::TAP_CNT_RST;
    n_phase = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_taps(TAP_CNT_BITS'(dir_rows[i].taps));
      else
        send_beat(dir_rows[i].cmd, IDX_BITS'(dir_rows[i].idx), SAMPLE_BITS'(dir_rows[i].val),
                  dir_rows[i].known, OUT_BITS'(dir_rows[i].sum));
    end

    while (n_items < ITEMS) begin
      case (n_phase)
        0: t = 7'd127;
        1: t = 7'd0;
        2: t = 7'd1;
        3: t = 7'd65;
        4: t = 7'd64;
        default: begin
          case ($urandom_range(0, 9))
            0, 1:    t = TAP_CNT_BITS'($urandom_range(17, 64));
            2:       t = TAP_CNT_BITS'($urandom_range(0, 127));
            default: t = TAP_CNT_BITS'($urandom_range(1, 16));
          endcase
        end
      endcase
      set_taps(t);
      n = active_taps(t);
      // receiver holds off for a long stretch while beats keep coming
      if (n_phase == 2 || n_phase == 7) hold_asked++;
      if ($urandom_range(0, 1) == 1) begin
        for (int k = 0; k < n; k++)
          send_beat(cfd_pkg::CMD_LOAD, IDX_BITS'(k), rand_sample(), 1'b0, '0);
      end
      repeat ($urandom_range(60, 200)) begin
        if ($urandom_range(0, 99) < 30) begin
          idx = ($urandom_range(0, 9) < 7) ? IDX_BITS'($urandom_range(0, n - 1))
                                           : IDX_BITS'($urandom);
          send_beat(cfd_pkg::CMD_LOAD, idx, rand_sample(), 1'b0, '0);
        end else begin
          send_beat(cfd_pkg::CMD_PUSH, IDX_BITS'($urandom), rand_sample(), 1'b0, '0);
        end
      end
      n_phase++;
    end

    drain();
    $display("beats: %0d coefficient loads, %0d sample pushes, %0d sums checked",
             n_loads, n_pushes, n_checked);
    $display("tap count written %0d times over %0d random phases, %0d mismatches",
             n_cfg, n_phase, n_errors);
    if (n_errors == 0) begin
      $display("circular_fir_dot_product test passed");
    end else begin
      $display("circular_fir_dot_product test failed");
    end
    $finish;
  end

  initial begin : sink
    int pat_left;
    logic [15:0] pat;
    bit quiet;
    pat_left = 0;
    pat      = '1;
    quiet    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (pat_left == 0) begin
        pat_left = $urandom_range(20, 200);
        pat      = 16'($urandom) | 16'h0001;
        quiet    = ($urandom_range(0, 3) == 0);
      end
      pat_left--;
      pat = {pat[14:0], pat[15]};
      m_axis_tready <= quiet | pat[0];
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_sums.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected result beat: tdata %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== {2'b00, pending_sums[0]}) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("sum %0d: expected %h got %h", n_checked,
                     {2'b00, pending_sums[0]}, m_axis_tdata);
        end
        void'(pending_sums.pop_front());
        n_checked++;
      end
    end
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("circular_fir_dot_product test failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cfd_pkg.sv
rtl/cfd_ram.sv
rtl/cfd_ctrl.sv
rtl/cfd_datapath.sv
rtl/circular_fir_dot_product.sv
test/testbench.sv
